/* sv/assert_macros.svh */
// Assertion macros used by the RTL of the spline evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, switched off while reset is low.
`define CBSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check on the rising edge of clk that also runs through reset.
`define CBSE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/cbse_pkg.sv */
// Types and constants of the cubic B-spline evaluator.
package cbse_pkg;

  // Command codes carried in the cmd field of an input word.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes and port widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_KNOT_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_PATCH_DIM = 2'd1;

  localparam int KC_W  = 7;
  localparam int INV_W = 32;
  localparam logic [KC_W-1:0]  KNOT_COUNT_RST    = 7'd4;
  localparam logic [INV_W-1:0] INV_PATCH_DIM_RST = 32'd16777216;

  // Product of position and reciprocal spacing, Q24.40.
  localparam int POS_W   = 32;
  localparam int PROD_W  = 64;
  localparam int SEG_LSB = 40;

  // Extended control points need two bits above the stored Q16.16 value.
  localparam int PT_W  = 32;
  localparam int EXT_W = 34;

  // Division by three as a multiply by (2^35 + 1) / 3, split in two halves.
  localparam int DIV3_SHIFT = 35;
  localparam int DIV3_SPLIT = 17;
  localparam int DIV3_IN_W  = 33;
  localparam int DIV3_M_W   = 34;
  localparam int DIV3_PART_W = DIV3_IN_W + DIV3_SPLIT;
  localparam int DIV3_FULL_W = DIV3_IN_W + DIV3_M_W;
  localparam logic [DIV3_M_W-1:0] DIV3_MULT = 34'd11453246123;
  localparam logic [DIV3_SPLIT-1:0] DIV3_LO = DIV3_MULT[DIV3_SPLIT-1:0];
  localparam logic [DIV3_SPLIT-1:0] DIV3_HI = DIV3_MULT[DIV3_M_W-1:DIV3_SPLIT];

  // Result queue behind the arithmetic pipeline.
  localparam int OQ_DEPTH = 16;
  localparam int OQ_PTR_W = 4;
  localparam int OQ_CNT_W = 5;

  localparam logic [31:0] Y_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] Y_MIN_MAG = 32'h8000_0000;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         point_index;
    logic signed [31:0] point_value;
    logic [31:0]        x_pos;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] y_value;
    logic               out_of_range;
  } out_word_t;

endpackage

/* sv/cubic_bspline_evaluator.sv */
// Uniform cubic B-spline evaluator: control point table and query pipeline.
//
//   Channel  Handshake              Word            Direction
//   in       in_valid / in_ready    in_word_t       load or query word in
//   out      out_valid / out_ready  out_word_t      one result word per query
//   cfg      cfg_valid / cfg_ready  index + data    register write, always ready
//
// A query word passes through the pipeline stages and the result queue to out_valid;
// one word, load or query, is accepted every cycle while in_ready is high.
// A load produces no result word. in_ready falls only while 16 queries are
// in the pipeline or waiting in the 16-entry result queue, so a stalled out
// side keeps the input open until 16 queries are held.
// Reset is synchronous and clears the pipeline, the queue and the registers;
// the control point table is not cleared and must be loaded before use.
module cubic_bspline_evaluator #(
  parameter int MAX_KNOTS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  cbse_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cbse_pkg::out_word_t                 out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cbse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbse_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cbse_pkg::*;

`include "assert_macros.svh"

  // Table address width and width of the clamped knot count.
  localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
  localparam int NW = $clog2(MAX_KNOTS + 1);
  // Fraction with one extra bit so that it can hold exactly one.
  localparam int VW  = FRAC_BITS + 1;
  localparam int SQW = 2 * VW;
  // Six times the basis weights lie well inside +/- 8 * one.
  localparam int WW = FRAC_BITS + 4;
  localparam int PW = WW + EXT_W;
  localparam int SW = PW + 2;
  localparam int TW = SW - FRAC_BITS - 1;

  localparam logic [VW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [WW-1:0] K3 = WW'(3);
  localparam logic signed [WW-1:0] K6 = WW'(6);
  localparam logic [SW-1:0] RND  = SW'(3) << FRAC_BITS;
  localparam logic [SW-1:0] RND1 = RND + SW'(1);

  // ------------------------------------------------------------------------
  // Configuration registers. The user must write them only while the block is idle; the block does not enforce this.
  // ------------------------------------------------------------------------
  logic [KC_W-1:0]  knot_count_r;
  logic [INV_W-1:0] inv_patch_dim_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_count_r    <= KNOT_COUNT_RST;
      inv_patch_dim_r <= INV_PATCH_DIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KNOT_COUNT:    knot_count_r    <= cfg_data[KC_W-1:0];
        CFG_INV_PATCH_DIM: inv_patch_dim_r <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // Input acceptance and result credits. Every accepted query holds one
  // credit until its result word leaves the queue, so the queue never
  // overflows and the pipeline itself never stalls.
  // ------------------------------------------------------------------------
  logic [OQ_CNT_W-1:0] used_r, used_nxt;
  logic [OQ_CNT_W-1:0] oq_cnt_r, oq_cnt_nxt;
  logic [OQ_PTR_W-1:0] oq_wr_r, oq_rd_r;
  logic in_acc, q_acc, oq_push, oq_pop;

  assign in_ready = (used_r < OQ_CNT_W'(OQ_DEPTH));
  assign in_acc   = in_valid && in_ready;
  assign q_acc    = in_acc && (in_word.cmd == CMD_QUERY);
  assign oq_pop   = out_valid && out_ready;

  always_comb begin
    used_nxt = used_r;
    if (q_acc && !oq_pop) begin
      used_nxt = used_r + OQ_CNT_W'(1);
    end else if (!q_acc && oq_pop) begin
      used_nxt = used_r - OQ_CNT_W'(1);
    end
  end

  // ------------------------------------------------------------------------
  // Stage 1: the word is registered together with the exact Q24.40 product
  // of position and reciprocal knot spacing.
  // ------------------------------------------------------------------------
  logic                 s1_vld_r;
  logic                 s1_cmd_r;
  logic [5:0]           s1_idx_r;
  logic signed [PT_W-1:0] s1_val_r;
  logic [PROD_W-1:0]    s1_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd_r <= in_word.cmd;
    s1_idx_r <= in_word.point_index;
    s1_val_r <= in_word.point_value;
    s1_p_r   <= PROD_W'(in_word.x_pos) * PROD_W'(inv_patch_dim_r);
  end

  // ------------------------------------------------------------------------
  // Stage 1 to 2: segment selection and table access. Loads write the table
  // here and queries read it here, so each query sees exactly the loads that
  // were accepted before it, without any forwarding.
  // ------------------------------------------------------------------------
  logic [NW-1:0] n_eff, n_m1, n_m2;
  logic [PROD_W-1:0] last_knot;
  logic p_ge_last, p_gt_last;
  logic [AW-1:0] seg_pv;
  logic [VW-1:0] seg_v;
  logic at_first, at_last;
  logic [AW-1:0] rd_a0, rd_a1, rd_a2, rd_a3;
  logic [31:0] load_idx;
  logic mem_we, mem_re;
  logic [AW-1:0] mem_wa;

  // The knot count register may hold any value; it is clamped to the table.
  always_comb begin
    if (knot_count_r < KC_W'(2)) begin
      n_eff = NW'(2);
    end else if (32'(knot_count_r) > MAX_KNOTS) begin
      n_eff = NW'(MAX_KNOTS);
    end else begin
      n_eff = NW'(knot_count_r);
    end
  end

  assign n_m1      = n_eff - NW'(1);
  assign n_m2      = n_eff - NW'(2);
  assign last_knot = PROD_W'(n_m1) << SEG_LSB;
  assign p_ge_last = (s1_p_r >= last_knot);
  assign p_gt_last = (s1_p_r > last_knot);

  // At or past the last knot the final segment is used at fraction one.
  assign seg_pv = p_ge_last ? n_m2[AW-1:0] : s1_p_r[SEG_LSB +: AW];
  assign seg_v  = p_ge_last ? ONE : {1'b0, s1_p_r[SEG_LSB-1 -: FRAC_BITS]};

  assign at_first = (seg_pv == '0);
  assign at_last  = (seg_pv == n_m2[AW-1:0]);

  // The four reads are q[pv-1] .. q[pv+2]. The end points outside the table
  // are extrapolated later from the two middle reads, so the outer addresses
  // fall back to a middle one there and never leave the table.
  assign rd_a1 = seg_pv;
  assign rd_a2 = seg_pv + AW'(1);
  assign rd_a0 = at_first ? rd_a1 : (seg_pv - AW'(1));
  assign rd_a3 = at_last  ? rd_a2 : (seg_pv + AW'(2));

  // A load beyond the table is dropped.
  assign load_idx = 32'(s1_idx_r);
  assign mem_we   = s1_vld_r && (s1_cmd_r == CMD_LOAD) && (load_idx < MAX_KNOTS);
  assign mem_wa   = load_idx[AW-1:0];
  assign mem_re   = s1_vld_r && (s1_cmd_r == CMD_QUERY);

  // Two copies of the table, each with one write and two read ports, give
  // the four reads a query needs in the same cycle.
  logic signed [PT_W-1:0] cp_mem_a_r [MAX_KNOTS];
  logic signed [PT_W-1:0] cp_mem_b_r [MAX_KNOTS];
  logic signed [PT_W-1:0] s2_m0_r, s2_m1_r, s2_m2_r, s2_m3_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cp_mem_a_r[mem_wa] <= s1_val_r;
    end
    if (mem_re) begin
      s2_m0_r <= cp_mem_a_r[rd_a0];
      s2_m1_r <= cp_mem_a_r[rd_a1];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cp_mem_b_r[mem_wa] <= s1_val_r;
    end
    if (mem_re) begin
      s2_m2_r <= cp_mem_b_r[rd_a2];
      s2_m3_r <= cp_mem_b_r[rd_a3];
    end
  end

  logic          s2_vld_r;
  logic [VW-1:0] s2_v_r;
  logic          s2_oor_r, s2_first_r, s2_last_r;

  always_ff @(posedge clk) begin
    s2_v_r     <= seg_v;
    s2_oor_r   <= p_gt_last;
    s2_first_r <= at_first;
    s2_last_r  <= at_last;
  end

  // ------------------------------------------------------------------------
  // Stage 2 to 3: squares of v and u = one - v, and the extended points.
  // ------------------------------------------------------------------------
  logic [VW-1:0] s2_u;
  logic [SQW-1:0] v_sq, u_sq;
  logic signed [EXT_W-1:0] e0, e1, e2, e3;

  assign s2_u = ONE - s2_v_r;
  assign v_sq = SQW'(s2_v_r) * SQW'(s2_v_r);
  assign u_sq = SQW'(s2_u) * SQW'(s2_u);

  assign e1 = EXT_W'(s2_m1_r);
  assign e2 = EXT_W'(s2_m2_r);
  assign e0 = s2_first_r ? ((e1 <<< 1) - e2) : EXT_W'(s2_m0_r);
  assign e3 = s2_last_r  ? ((e2 <<< 1) - e1) : EXT_W'(s2_m3_r);

  logic          s3_vld_r, s3_oor_r;
  logic [VW-1:0] s3_v_r, s3_u_r, s3_v2_r, s3_u2_r;
  logic signed [EXT_W-1:0] s3_q0_r, s3_q1_r, s3_q2_r, s3_q3_r;

  always_ff @(posedge clk) begin
    s3_oor_r <= s2_oor_r;
    s3_v_r   <= s2_v_r;
    s3_u_r   <= s2_u;
    s3_v2_r  <= v_sq[FRAC_BITS +: VW];
    s3_u2_r  <= u_sq[FRAC_BITS +: VW];
    s3_q0_r  <= e0;
    s3_q1_r  <= e1;
    s3_q2_r  <= e2;
    s3_q3_r  <= e3;
  end

  // ------------------------------------------------------------------------
  // Stage 3 to 4: cubes.
  // ------------------------------------------------------------------------
  logic [SQW-1:0] v_cu, u_cu;

  assign v_cu = SQW'(s3_v2_r) * SQW'(s3_v_r);
  assign u_cu = SQW'(s3_u2_r) * SQW'(s3_u_r);

  logic          s4_vld_r, s4_oor_r;
  logic [VW-1:0] s4_v_r, s4_v2_r, s4_v3_r, s4_u3_r;
  logic signed [EXT_W-1:0] s4_q0_r, s4_q1_r, s4_q2_r, s4_q3_r;

  always_ff @(posedge clk) begin
    s4_oor_r <= s3_oor_r;
    s4_v_r   <= s3_v_r;
    s4_v2_r  <= s3_v2_r;
    s4_v3_r  <= v_cu[FRAC_BITS +: VW];
    s4_u3_r  <= u_cu[FRAC_BITS +: VW];
    s4_q0_r  <= s3_q0_r;
    s4_q1_r  <= s3_q1_r;
    s4_q2_r  <= s3_q2_r;
    s4_q3_r  <= s3_q3_r;
  end

  // ------------------------------------------------------------------------
  // Stage 4 to 5: basis weights, each six times the basis function.
  // ------------------------------------------------------------------------
  logic signed [WW-1:0] ev, ev2, ev3, eu3, eone;
  logic signed [WW-1:0] w0, w1, w2, w3;

  assign ev   = signed'(WW'(s4_v_r));
  assign ev2  = signed'(WW'(s4_v2_r));
  assign ev3  = signed'(WW'(s4_v3_r));
  assign eu3  = signed'(WW'(s4_u3_r));
  assign eone = signed'(WW'(ONE));

  assign w0 = eu3;
  assign w1 = K3 * ev3 - K6 * ev2 + (eone <<< 2);
  assign w2 = K3 * (ev2 - ev3) + K3 * ev + eone;
  assign w3 = ev3;

  logic s5_vld_r, s5_oor_r;
  logic signed [WW-1:0]    s5_w0_r, s5_w1_r, s5_w2_r, s5_w3_r;
  logic signed [EXT_W-1:0] s5_q0_r, s5_q1_r, s5_q2_r, s5_q3_r;

  always_ff @(posedge clk) begin
    s5_oor_r <= s4_oor_r;
    s5_w0_r  <= w0;
    s5_w1_r  <= w1;
    s5_w2_r  <= w2;
    s5_w3_r  <= w3;
    s5_q0_r  <= s4_q0_r;
    s5_q1_r  <= s4_q1_r;
    s5_q2_r  <= s4_q2_r;
    s5_q3_r  <= s4_q3_r;
  end

  // ------------------------------------------------------------------------
  // Stage 5 to 6: four weighted points. Stages 7 and 8 sum them as a tree.
  // ------------------------------------------------------------------------
  logic s6_vld_r, s6_oor_r;
  logic signed [PW-1:0] s6_pr0_r, s6_pr1_r, s6_pr2_r, s6_pr3_r;

  always_ff @(posedge clk) begin
    s6_oor_r <= s5_oor_r;
    s6_pr0_r <= PW'(s5_w0_r) * PW'(s5_q0_r);
    s6_pr1_r <= PW'(s5_w1_r) * PW'(s5_q1_r);
    s6_pr2_r <= PW'(s5_w2_r) * PW'(s5_q2_r);
    s6_pr3_r <= PW'(s5_w3_r) * PW'(s5_q3_r);
  end

  logic s7_vld_r, s7_oor_r;
  logic signed [SW-1:0] s7_sa_r, s7_sb_r;

  always_ff @(posedge clk) begin
    s7_oor_r <= s6_oor_r;
    s7_sa_r  <= SW'(s6_pr0_r) + SW'(s6_pr1_r);
    s7_sb_r  <= SW'(s6_pr2_r) + SW'(s6_pr3_r);
  end

  logic s8_vld_r, s8_oor_r;
  logic signed [SW-1:0] s8_s_r;

  always_ff @(posedge clk) begin
    s8_oor_r <= s7_oor_r;
    s8_s_r   <= s7_sa_r + s7_sb_r;
  end

  // ------------------------------------------------------------------------
  // Stage 8 to 9: magnitude plus half of 6 * one, then the power-of-two part
  // of the divisor. What is left is a division by three.
  // ------------------------------------------------------------------------
  logic s8_neg;
  logic [SW-1:0] s8_mag;

  assign s8_neg = s8_s_r[SW-1];
  assign s8_mag = s8_neg ? (~s8_s_r + RND1) : (s8_s_r + RND);

  logic s9_vld_r, s9_oor_r, s9_neg_r;
  logic [TW-1:0] s9_t_r;

  always_ff @(posedge clk) begin
    s9_oor_r <= s8_oor_r;
    s9_neg_r <= s8_neg;
    s9_t_r   <= s8_mag[SW-1:FRAC_BITS+1];
  end

  // ------------------------------------------------------------------------
  // Stage 9 to 10: the reciprocal of three as two partial products. A value
  // at or above 2^33 saturates whatever its low bits give.
  // ------------------------------------------------------------------------
  logic [DIV3_IN_W-1:0] s9_t_lo;

  assign s9_t_lo = s9_t_r[DIV3_IN_W-1:0];

  logic s10_vld_r, s10_oor_r, s10_neg_r, s10_ovf_r;
  logic [DIV3_PART_W-1:0] s10_pl_r, s10_ph_r;

  always_ff @(posedge clk) begin
    s10_oor_r <= s9_oor_r;
    s10_neg_r <= s9_neg_r;
    s10_ovf_r <= |s9_t_r[TW-1:DIV3_IN_W];
    s10_pl_r  <= DIV3_PART_W'(s9_t_lo) * DIV3_PART_W'(DIV3_LO);
    s10_ph_r  <= DIV3_PART_W'(s9_t_lo) * DIV3_PART_W'(DIV3_HI);
  end

  // Valid bits of stages 2 to 10 carry queries only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      s7_vld_r  <= 1'b0;
      s8_vld_r  <= 1'b0;
      s9_vld_r  <= 1'b0;
      s10_vld_r <= 1'b0;
    end else begin
      s2_vld_r  <= mem_re;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= s4_vld_r;
      s6_vld_r  <= s5_vld_r;
      s7_vld_r  <= s6_vld_r;
      s8_vld_r  <= s7_vld_r;
      s9_vld_r  <= s8_vld_r;
      s10_vld_r <= s9_vld_r;
    end
  end

  // ------------------------------------------------------------------------
  // Stage 10 to queue: quotient, sign and saturation.
  // ------------------------------------------------------------------------
  logic [DIV3_FULL_W-1:0] div_full;
  logic [31:0] quot;
  out_word_t push_word;

  assign div_full = DIV3_FULL_W'(s10_pl_r) + (DIV3_FULL_W'(s10_ph_r) << DIV3_SPLIT);
  assign quot     = div_full[DIV3_SHIFT +: 32];

  always_comb begin
    push_word.out_of_range = s10_oor_r;
    if (s10_neg_r) begin
      if (s10_ovf_r || (quot > Y_MIN_MAG)) begin
        push_word.y_value = signed'(Y_MIN_MAG);
      end else begin
        push_word.y_value = signed'(~quot + 32'd1);
      end
    end else begin
      if (s10_ovf_r || (quot > Y_MAX)) begin
        push_word.y_value = signed'(Y_MAX);
      end else begin
        push_word.y_value = signed'(quot);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Result queue.
  // ------------------------------------------------------------------------
  out_word_t oq_mem_r [OQ_DEPTH];

  assign oq_push = s10_vld_r;

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (oq_push && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + OQ_CNT_W'(1);
    end else if (!oq_push && oq_pop) begin
      oq_cnt_nxt = oq_cnt_r - OQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem_r[oq_wr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      oq_cnt_r <= '0;
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
    end else begin
      used_r   <= used_nxt;
      oq_cnt_r <= oq_cnt_nxt;
      if (oq_push) begin
        oq_wr_r <= oq_wr_r + OQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + OQ_PTR_W'(1);
      end
    end
  end

  assign out_valid = (oq_cnt_r != '0);
  assign out_word  = oq_mem_r[oq_rd_r];

  // ------------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------------
  logic [9:0] inflight;

  assign inflight = {mem_re, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r,
                     s7_vld_r, s8_vld_r, s9_vld_r, s10_vld_r};

  // Every held credit belongs to a query in the pipeline or in the queue.
  `CBSE_ASSERT(a_credit_count, 32'(used_r) == $countones(inflight) + 32'(oq_cnt_r), "credit count does not match queries in flight")
  // The queue is never written while full unless a word leaves in the same cycle.
  `CBSE_ASSERT(a_queue_no_overflow, !(oq_push && !oq_pop && (oq_cnt_r == OQ_CNT_W'(OQ_DEPTH))), "result queue overflow")
  // Reset leaves no credits, no queued words and no word in the first stage.
  `CBSE_ASSERT_RST(a_reset_clears, !rst_n |=> (used_r == '0 && oq_cnt_r == '0 && !s1_vld_r), "reset did not clear the control state")

endmodule
